/* rtl/svis_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svis_pkg
// shared types and constants for the shadowcast visibility engine
// ----------------------------------------------------------------------------
package svis_pkg;

  localparam int FW = 5;

  typedef struct packed {
    logic [FW-1:0] sn;
    logic [FW-1:0] sd;
    logic [FW-1:0] en;
    logic [FW-1:0] ed;
  } span_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_DONE
  } state_t;

  // a/b < c/d, positive denominators
  function automatic logic fr_lt(input logic [FW-1:0] a, input logic [FW-1:0] b,
                                 input logic [FW-1:0] c, input logic [FW-1:0] d);
    logic [2*FW-1:0] l;
    logic [2*FW-1:0] r;
    l = a * d;
    r = c * b;
    return l < r;
  endfunction

endpackage

/* rtl/shadowcast_visibility_engine_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shadowcast_visibility_engine_core
// shadowcasting field-of-view engine, one tile per command
// ----------------------------------------------------------------------------
// usage: raise start with the tile fields while busy is low; the tile is taken
// at that edge and busy rises. one result beat follows on done, valid for one
// cycle only; the receiver cannot hold it off.
// the shadow intervals live in a single-port-read memory with a registered
// read. a tile first walks all stored intervals, looking for one that covers
// its projection and for the sorted insert position, then passes through a
// decide state. an insert, merge or removal then writes entries one at a
// time, each read then written. done follows the decide state directly when
// nothing is written, else the last write; busy drops in the cycle after
// done. worst case is an insert at the front of a list of MAX_SHADOWS-1
// entries: MAX_SHADOWS writes.
// octant_start clears the count and flag before the walk.
// an insert into a full list writes nothing and raises list_overflow.
// reset clears count, flag and the controller; memory contents are left as
// they are, the count guards every read.
// ----------------------------------------------------------------------------
module shadowcast_visibility_engine_core import svis_pkg::*; #(
  parameter int SIGHT_RANGE = 10,
  parameter int MAX_SHADOWS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  octant_start,
  input  logic [2:0]            octant,
  input  logic [3:0]            scan_row,
  input  logic [3:0]            scan_col,
  input  logic                  tile_blocked,
  input  logic                  tile_on_map,
  output logic                  done,
  output logic                  tile_visible,
  output logic signed [4:0]     offset_x,
  output logic signed [4:0]     offset_y,
  output logic                  line_full,
  output logic                  list_overflow
);

  localparam int AW = (MAX_SHADOWS > 1) ? $clog2(MAX_SHADOWS) : 1;
  localparam int CW = $clog2(MAX_SHADOWS + 1);

  state_t state, state_next;

  // registered tile
  span_t         p;
  logic          ins_ok;    // blocked and on map
  logic          active;    // not full and within sight range
  logic [2:0]    oct;
  logic [3:0]    row, col;
  logic          on_map;

  logic [CW-1:0] count;
  logic          full_flag;
  logic          covered;
  logic [CW-1:0] scan_i;     // address issued
  logic          rd_vld;     // read data valid this cycle
  logic [CW-1:0] rd_i;       // index of data on rdata
  logic          idx_found;
  logic [CW-1:0] idx;
  span_t         prev_e, next_e;
  logic          dropped;

  // shift sequencer
  logic          shift_dn;   // 1: remove entry (move down), 0: open gap (move up)
  logic [CW-1:0] sh_k;
  logic [CW-1:0] sh_end;
  logic          sh_ph;      // 0 issue read, 1 write
  span_t         final_w;
  logic [CW-1:0] final_a;
  logic [CW-1:0] count_after;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  span_t         wdata, rdata;

  svis_mem #(.DEPTH(MAX_SHADOWS), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // merge decisions, from walk results
  logic has_prev, has_next, do_ins, need_drop;
  always_comb begin
    has_prev  = (idx != '0) && fr_lt(p.sn, p.sd, prev_e.en, prev_e.ed);
    has_next  = (idx < count) && fr_lt(next_e.sn, next_e.sd, p.en, p.ed);
    do_ins    = active && !covered && ins_ok;
    need_drop = !has_prev && !has_next && (count >= CW'(MAX_SHADOWS));
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start) state_next = ST_SCAN;
      ST_SCAN:   if (!rd_vld && scan_i >= count) state_next = ST_DECIDE;
      ST_DECIDE: state_next = (do_ins && !need_drop) ? ST_SHIFT : ST_DONE;
      ST_SHIFT:  if (sh_k == sh_end && sh_ph) state_next = ST_DONE;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = (state != ST_IDLE);
    done  = (state == ST_DONE);
    raddr = scan_i[AW-1:0];
    we    = 1'b0;
    waddr = final_a[AW-1:0];
    wdata = final_w;
    if (state == ST_SHIFT) begin
      if (shift_dn) raddr = AW'(sh_k + 1'b1);
      else          raddr = AW'(sh_k - 1'b1);
      if (sh_ph) begin
        we = 1'b1;
        if (sh_k == sh_end) begin
          waddr = final_a[AW-1:0];
          wdata = final_w;
        end else begin
          waddr = sh_k[AW-1:0];
          wdata = rdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      full_flag <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: if (start) begin
          if (octant_start) begin
            count     <= '0;
            full_flag <= 1'b0;
          end
        end
        ST_DECIDE: ;
        ST_SHIFT: if (sh_k == sh_end && sh_ph) begin
          count <= count_after;
          // full test on new entry zero, taken from the final write
          full_flag <= (count_after == CW'(1)) && (final_a == '0) &&
                       (final_w.sn == '0) && (final_w.en == final_w.ed);
        end
        default: ;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (start) begin
        p.sn    <= FW'(scan_col);
        p.sd    <= FW'(scan_row) + FW'(2);
        p.en    <= FW'(scan_col) + FW'(1);
        p.ed    <= FW'(scan_row) + FW'(1);
        active  <= !(full_flag && !octant_start) && (32'(scan_row) < SIGHT_RANGE);
        ins_ok  <= tile_blocked && tile_on_map;
        on_map  <= tile_on_map;
        oct     <= octant;
        row     <= scan_row;
        col     <= scan_col;
        covered <= 1'b0;
        scan_i  <= '0;
        rd_vld  <= 1'b0;
        idx_found <= 1'b0;
        idx     <= '0;
        dropped <= 1'b0;
      end
      ST_SCAN: begin
        rd_vld <= (scan_i < count);
        rd_i   <= scan_i;
        if (scan_i < count) scan_i <= scan_i + 1'b1;
        if (rd_vld) begin
          if (!fr_lt(p.sn, p.sd, rdata.sn, rdata.sd) &&
              !fr_lt(rdata.en, rdata.ed, p.en, p.ed))
            covered <= 1'b1;
          if (!idx_found) begin
            if (fr_lt(rdata.sn, rdata.sd, p.sn, p.sd)) begin
              idx    <= rd_i + 1'b1;
              prev_e <= rdata;
            end else begin
              idx_found <= 1'b1;
              next_e    <= rdata;
            end
          end
        end
      end
      ST_DECIDE: begin
        sh_ph <= 1'b0;
        if (has_next && has_prev) begin
          shift_dn    <= 1'b1;
          sh_k        <= idx;
          sh_end      <= idx - 1'b1;
          final_a     <= idx - 1'b1;
          final_w     <= '{sn: prev_e.sn, sd: prev_e.sd, en: next_e.en, ed: next_e.ed};
          count_after <= count - 1'b1;
          // close the gap first, then write the merged entry
          if (count - 1'b1 > idx) begin
            sh_end <= count - 1'b1;
            sh_k   <= idx;
          end else begin
            sh_k   <= idx - 1'b1;
          end
        end else if (has_next) begin
          shift_dn <= 1'b1; sh_k <= idx; sh_end <= idx; final_a <= idx;
          final_w  <= '{sn: p.sn, sd: p.sd, en: next_e.en, ed: next_e.ed};
          count_after <= count;
        end else if (has_prev) begin
          shift_dn <= 1'b1; sh_k <= idx - 1'b1; sh_end <= idx - 1'b1;
          final_a  <= idx - 1'b1;
          final_w  <= '{sn: prev_e.sn, sd: prev_e.sd, en: p.en, ed: p.ed};
          count_after <= count;
        end else if (count >= CW'(MAX_SHADOWS)) begin
          // list full: nothing is written, the beat flags the drop
          dropped <= do_ins;
          shift_dn <= 1'b1; sh_k <= '0; sh_end <= '0;
          final_a <= '0; final_w <= '0; count_after <= count;
        end else begin
          shift_dn <= 1'b0; sh_k <= count; sh_end <= idx; final_a <= idx;
          final_w <= p; count_after <= count + 1'b1;
        end
      end
      ST_SHIFT: begin
        sh_ph <= !sh_ph;
        if (sh_ph && sh_k != sh_end) begin
          if (shift_dn) begin
            sh_k <= sh_k + 1'b1;
            // merged pair: after the gap closes, write at idx-1
            if (sh_k + 1'b1 == sh_end) begin
              sh_k   <= final_a;
              sh_end <= final_a;
            end
          end else begin
            sh_k <= sh_k - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // octant transform of the registered row and column
  logic [4:0] c5, r5;
  always_comb begin
    c5 = {1'b0, col};
    r5 = {1'b0, row};
    case (oct)
      3'd0: begin offset_x = c5;  offset_y = -r5; end
      3'd1: begin offset_x = r5;  offset_y = -c5; end
      3'd2: begin offset_x = r5;  offset_y = c5;  end
      3'd3: begin offset_x = c5;  offset_y = r5;  end
      3'd4: begin offset_x = -c5; offset_y = r5;  end
      3'd5: begin offset_x = -r5; offset_y = c5;  end
      3'd6: begin offset_x = -r5; offset_y = -c5; end
      default: begin offset_x = -c5; offset_y = -r5; end
    endcase
    tile_visible  = active && !covered && on_map;
    line_full     = full_flag;
    list_overflow = dropped;
  end

  // assertions
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_SHADOWS)) else $error("count overflow");
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("done while idle");

endmodule

/* rtl/svis_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svis_mem
// shadow interval store, one write port and one registered read port
// ----------------------------------------------------------------------------
module svis_mem import svis_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  span_t         wdata,
  input  logic [AW-1:0] raddr,
  output span_t         rdata
);

  span_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sim/tb_shadowcast_visibility_engine_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shadowcast_visibility_engine_core
// self-checking bench for the shadowcast visibility engine
// ----------------------------------------------------------------------------
// tiles are queued by an initial block and fed one command beat at a time by
// a clocked driver. each accepted tile is run through a local shadow-list
// predictor, whose result waits in a queue. the monitor takes every done beat
// and checks it field by field against the oldest waiting result. stimulus
// is a directed opening, then mostly well-formed octant scans with random
// walls, mixed with pure noise tiles.
// ----------------------------------------------------------------------------
module tb_shadowcast_visibility_engine_core;
  import svis_pkg::*;

  localparam int SIGHT = 10;
  localparam int DEPTH = 16;

  typedef struct {
    bit       first;
    bit [2:0] oct;
    bit [3:0] row;
    bit [3:0] col;
    bit       wall;
    bit       on_map;
    bit       drain;   // hold this tile back until nothing is outstanding
  } tile_t;

  typedef struct {
    bit              vis;
    logic signed [4:0] ox;
    logic signed [4:0] oy;
    bit              full;
    bit              ovf;
  } view_t;

  // exact fraction interval, numerators and denominators kept apart
  typedef struct {
    int sn, sd, en, ed;
  } arc_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic octant_start = 0;
  logic [2:0] octant = 0;
  logic [3:0] scan_row = 0;
  logic [3:0] scan_col = 0;
  logic tile_blocked = 0;
  logic tile_on_map = 0;
  logic busy, done, tile_visible, line_full, list_overflow;
  logic signed [4:0] offset_x, offset_y;

  shadowcast_visibility_engine_core #(.SIGHT_RANGE(SIGHT), .MAX_SHADOWS(DEPTH)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .octant_start(octant_start), .octant(octant), .scan_row(scan_row),
    .scan_col(scan_col), .tile_blocked(tile_blocked), .tile_on_map(tile_on_map),
    .done(done), .tile_visible(tile_visible), .offset_x(offset_x),
    .offset_y(offset_y), .line_full(line_full), .list_overflow(list_overflow)
  );

  always #5 clk = ~clk;

  tile_t pending_tiles[$];
  view_t expected_views[$];
  int    errors = 0;
  int    tiles_taken = 0;
  int    idle_pct = 13;
  tile_t cur;

  // predictor state: sorted disjoint shadow arcs, count and full flag
  arc_t shade[DEPTH];
  int   shade_n = 0;
  bit   shade_full = 0;

  function automatic bit frac_lt(int a, int b, int c, int d);
    return a * d < c * b;
  endfunction

  // insert or merge an arc, returns 1 when a new entry had to be dropped
  function automatic bit fold_arc(arc_t p);
    int  idx;
    bit  prv, nxt;
    idx = 0;
    while (idx < shade_n && frac_lt(shade[idx].sn, shade[idx].sd, p.sn, p.sd))
      idx++;
    prv = idx > 0 && frac_lt(p.sn, p.sd, shade[idx-1].en, shade[idx-1].ed);
    nxt = idx < shade_n && frac_lt(shade[idx].sn, shade[idx].sd, p.en, p.ed);
    if (prv && nxt) begin
      shade[idx-1].en = shade[idx].en;
      shade[idx-1].ed = shade[idx].ed;
      for (int k = idx; k + 1 < shade_n; k++) shade[k] = shade[k+1];
      shade_n--;
    end else if (nxt) begin
      shade[idx].sn = p.sn;
      shade[idx].sd = p.sd;
    end else if (prv) begin
      shade[idx-1].en = p.en;
      shade[idx-1].ed = p.ed;
    end else begin
      if (shade_n >= DEPTH) return 1;
      for (int k = shade_n; k > idx; k--) shade[k] = shade[k-1];
      shade[idx] = p;
      shade_n++;
    end
    return 0;
  endfunction

  function automatic view_t cast_tile(tile_t t);
    view_t v;
    arc_t  p;
    bit    seen;
    int    r, c, x, y;
    r = int'(t.row);
    c = int'(t.col);
    seen = 0;
    v.ovf = 0;
    if (t.first) begin
      shade_n = 0;
      shade_full = 0;
    end
    if (!shade_full && r < SIGHT) begin
      p.sn = c; p.sd = r + 2; p.en = c + 1; p.ed = r + 1;
      seen = 1;
      for (int i = 0; i < shade_n; i++)
        if (!frac_lt(p.sn, p.sd, shade[i].sn, shade[i].sd) &&
            !frac_lt(shade[i].en, shade[i].ed, p.en, p.ed))
          seen = 0;
      if (seen && t.on_map && t.wall) begin
        v.ovf = fold_arc(p);
        shade_full = shade_n == 1 && shade[0].sn == 0 && shade[0].en == shade[0].ed;
      end
    end
    case (t.oct)
      3'd0: begin x = c;  y = -r; end
      3'd1: begin x = r;  y = -c; end
      3'd2: begin x = r;  y = c;  end
      3'd3: begin x = c;  y = r;  end
      3'd4: begin x = -c; y = r;  end
      3'd5: begin x = -r; y = c;  end
      3'd6: begin x = -r; y = -c; end
      default: begin x = -c; y = -r; end
    endcase
    v.vis  = seen && t.on_map;
    v.ox   = x[4:0];
    v.oy   = y[4:0];
    v.full = shade_full;
    return v;
  endfunction

  // driver: one command beat per tile, held until busy is low at an edge
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_views.push_back(cast_tile(cur));
        tiles_taken++;
        if (tiles_taken == 250) idle_pct = 66;
        if (tiles_taken == 500) idle_pct = 0;
      end
      if (start && busy) begin
        // keep the beat on the port until it is taken
      end else if (pending_tiles.size() > 0 &&
                   !(pending_tiles[0].drain && (expected_views.size() > 0 || start)) &&
                   $urandom_range(99) >= idle_pct) begin
        cur = pending_tiles.pop_front();
        octant_start <= cur.first;
        octant       <= cur.oct;
        scan_row     <= cur.row;
        scan_col     <= cur.col;
        tile_blocked <= cur.wall;
        tile_on_map  <= cur.on_map;
        start        <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every done beat must match the oldest prediction
  always @(posedge clk) begin
    view_t e;
    if (!rst && done) begin
      if (expected_views.size() == 0) begin
        $error("result beat with no tile outstanding");
        errors++;
      end else begin
        e = expected_views.pop_front();
        if (tile_visible !== e.vis) begin
          $error("tile_visible exp %0d got %0d", e.vis, tile_visible); errors++;
        end
        if (offset_x !== e.ox) begin
          $error("offset_x exp %0d got %0d", e.ox, offset_x); errors++;
        end
        if (offset_y !== e.oy) begin
          $error("offset_y exp %0d got %0d", e.oy, offset_y); errors++;
        end
        if (line_full !== e.full) begin
          $error("line_full exp %0d got %0d", e.full, line_full); errors++;
        end
        if (list_overflow !== e.ovf) begin
          $error("list_overflow exp %0d got %0d", e.ovf, list_overflow); errors++;
        end
      end
    end
  end

  function automatic tile_t mk(bit f, int o, int r, int c, bit w, bit m);
    tile_t t;
    t.first = f; t.oct = 3'(o); t.row = 4'(r); t.col = 4'(c); t.wall = w; t.on_map = m;
    t.drain = 0;
    return t;
  endfunction

  // well-formed octant scan with random walls
  task automatic queue_octant();
    int o, depth, wall_pct;
    bit f;
    o = int'($urandom_range(7));
    depth = int'($urandom_range(SIGHT + 1, 2));
    wall_pct = int'($urandom_range(45, 5));
    f = 1;
    for (int r = 1; r <= depth; r++)
      for (int c = 0; c <= r; c++) begin
        pending_tiles.push_back(mk(f, o, r, c, $urandom_range(99) < wall_pct,
                                   $urandom_range(9) != 0));
        f = 0;
      end
  endtask

  initial begin
    tile_t t;
    // directed: every octant at the extremes, row zero, column past row,
    // beyond sight range, full shadow from a wall at row zero
    for (int o = 0; o < 8; o++)
      pending_tiles.push_back(mk(o == 0, o, (o & 1) ? 15 : 1, (o & 2) ? 15 : 0, 0, 1));
    pending_tiles.push_back(mk(1, 0, 0, 0, 1, 1));   // spans zero to one
    pending_tiles.push_back(mk(0, 3, 2, 1, 1, 1));   // full shadow, nothing seen
    pending_tiles.push_back(mk(1, 5, 12, 3, 1, 1));  // beyond sight
    pending_tiles.push_back(mk(0, 6, 9, 0, 1, 0));   // off map wall
    // sparse walls to grow the list, with gaps, then more
    for (int c = 0; c < 16; c += 2) pending_tiles.push_back(mk(c == 0, 2, 9, c, 1, 1));
    pending_tiles.push_back(mk(0, 4, 3, 9, 1, 1));
    pending_tiles.push_back(mk(0, 7, 1, 14, 1, 1));
    pending_tiles.push_back(mk(0, 1, 5, 2, 0, 1));
    // random part: mostly octant scans, some noise
    while (pending_tiles.size() < 760) begin
      if ($urandom_range(3) != 0) begin
        queue_octant();
      end else begin
        t = mk(1'($urandom_range(1)), int'($urandom_range(7)), int'($urandom_range(15)),
               int'($urandom_range(15)), 1'($urandom_range(1)), 1'($urandom_range(1)));
        pending_tiles.push_back(t);
      end
      if ($urandom_range(9) == 0) pending_tiles[pending_tiles.size()-1].drain = 1;
    end
    pending_tiles[400].drain = 1;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait (pending_tiles.size() == 0);
    @(posedge clk);
    while (start || expected_views.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && expected_views.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* filelist.f */
rtl/svis_pkg.sv
rtl/svis_mem.sv
rtl/shadowcast_visibility_engine_core.sv
sim/tb_shadowcast_visibility_engine_core.sv
